/* sv/scbs_pkg.sv */
// Shared constants for the CSR to blocked/remainder splitter.
// Field widths, request kinds, register indexes and divider step sizes.
// No dependencies.
package scbs_pkg;

   // request field widths
   localparam int COL_W   = 16;
   localparam int VALUE_W = 64;
   localparam int CNT_W   = 24;   // width of every count field on the result side
   localparam int BCOL_W  = 12;
   localparam int OFS_W   = 6;
   localparam int DIM_W   = 4;
   localparam int TAG_W   = 16;

   localparam int REQ_DATA_W = 80;   // col + value
   localparam int RSP_DATA_W = 200;  // 196 bits of fields, padded to bytes
   localparam int RSP_PAD_W  = 4;

   // request kinds on the input side
   localparam logic CMD_ENTRY   = 1'b0;
   localparam logic CMD_ROW_END = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BLOCKED   = 2'd0;
   localparam logic [1:0] KIND_REMAINDER = 2'd1;
   localparam logic [1:0] KIND_ROW_END   = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_BLOCK_ROWS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_COLS   = 2'd1;
   localparam logic [1:0] CSR_BLOCK_HEIGHT = 2'd2;
   localparam logic [1:0] CSR_BLOCK_WIDTH  = 2'd3;

   // column / width divider: quotient bits retired per cycle, and rounds
   localparam int DIV_STEP   = 4;
   localparam int DIV_ROUNDS = COL_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_ROUNDS);

   // clamp a block dimension into 1..8
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(8)) begin
         r = DIM_W'(8);
      end
      return r;
   endfunction

endpackage

/* sv/sparse_csr_to_mixed_block_split.sv */
// rsp_tvalid comes from the result register. Row-end and remainder requests pass only the
// issue state; blocked entries pass issue, the divider rounds at 4 quotient bits each, a slot
// table read and a tag compare/update. A request is taken only when idle, after the last
// one commits; a result held by rsp_tready stalls the sequencer before the next commit.
// Reset (synchronous): after reset the slot table is swept, one entry per cycle, over all
// TABLE_DEPTH entries, before the first request is accepted; config writes are taken.
// Top level of the CSR splitter; depends on scbs_pkg.
module sparse_csr_to_mixed_block_split #(
   parameter int TABLE_DEPTH = 4096,
   parameter int COUNT_BITS  = 24,
   parameter int VALUE_BITS  = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration
   input  logic                             csr_we,
   input  logic [1:0]                       csr_addr,
   input  logic [15:0]                      csr_wdata,
   // requests
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [scbs_pkg::REQ_DATA_W-1:0]  req_tdata,   // col[15:0], value[79:16]
   input  logic [0:0]                       req_tuser,   // cmd[0]
   // results
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scbs_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // block_slot[23:0], block_column[35:24], offset[41:36], new_block[42],
   // remainder_pos[66:43], col_out[82:67], value_out[146:83], row_pointer[170:147],
   // block_row_pointer[194:171], overflow[195], zero pad[199:196]
   output logic [1:0]                       rsp_tuser,   // kind[1:0]
   output logic                             rsp_tlast    // block_row_end
);

   localparam int AW      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W = 1 + scbs_pkg::TAG_W + COUNT_BITS;
   localparam int Q_W     = scbs_pkg::COL_W;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;
   localparam logic [2:0] ST_TAG   = 3'd5;

   // configuration registers
   logic [15:0]                     block_rows_ff;
   logic [12:0]                     block_cols_ff;
   logic [scbs_pkg::DIM_W-1:0]      block_height_ff;
   logic [scbs_pkg::DIM_W-1:0]      block_width_ff;

   // control and stream state
   logic [2:0]                      state_ff, state_in;
   logic [AW-1:0]                   clr_cnt_ff;
   logic [15:0]                     row_count_ff;
   logic [2:0]                      row_in_block_ff;
   logic [scbs_pkg::TAG_W-1:0]      tag_ff;
   logic [COUNT_BITS-1:0]           block_total_ff;
   logic [COUNT_BITS-1:0]           rem_total_ff;

   // captured request
   logic                            cmd_ff;
   logic [scbs_pkg::COL_W-1:0]      col_ff;
   logic [VALUE_BITS-1:0]           val_ff;

   // divider
   logic [Q_W-1:0]                  dvd_ff, dvd_in;
   logic [Q_W-1:0]                  quo_ff, quo_in;
   logic [scbs_pkg::DIM_W-1:0]      rem_ff, rem_in;
   logic [scbs_pkg::DIV_CNT_W-1:0]  div_cnt_ff;

   // slot table
   logic [ENTRY_W-1:0]              table_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0]              rd_ff;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [ENTRY_W-1:0]              mem_wdata;

   // result register
   logic                            rsp_valid_ff;
   logic [1:0]                      kind_ff, kind_in;
   logic [scbs_pkg::CNT_W-1:0]      bslot_ff, rpos_ff, rptr_ff, brptr_ff;
   logic [scbs_pkg::CNT_W-1:0]      bslot_in, rpos_in, rptr_in, brptr_in;
   logic [scbs_pkg::BCOL_W-1:0]     bcol_ff, bcol_in;
   logic [scbs_pkg::OFS_W-1:0]      ofs_ff, ofs_in;
   logic                            newb_ff, brend_ff, ovf_ff;
   logic                            newb_in, brend_in, ovf_in;
   logic [scbs_pkg::COL_W-1:0]      colout_ff, colout_in;
   logic [VALUE_BITS-1:0]           valout_ff, valout_in;

   // working signals
   logic [scbs_pkg::DIM_W-1:0]      h_eff, w_eff;
   logic                            accept, out_free, in_block_rows, blocked;
   logic                            closes_brow, commit;
   logic [16:0]                     row_next;
   logic [3:0]                      rib_next;
   logic [31:0]                     bt32, rt32, slot32;
   logic                            rd_valid, hit, tgt_over;
   logic [scbs_pkg::TAG_W-1:0]      rd_tag;
   logic [COUNT_BITS-1:0]           rd_slot;
   logic [scbs_pkg::OFS_W-1:0]      ofs_calc;

   assign h_eff    = scbs_pkg::clamp_dim(block_height_ff);
   assign w_eff    = scbs_pkg::clamp_dim(block_width_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept   = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign commit   = out_free && ((state_ff == ST_ISSUE && !blocked) || state_ff == ST_TAG);

   assign in_block_rows = (row_count_ff < block_rows_ff);
   assign blocked  = (cmd_ff == scbs_pkg::CMD_ENTRY) && in_block_rows &&
                     (col_ff < {3'b000, block_cols_ff});
   assign row_next = {1'b0, row_count_ff} + 17'd1;
   assign rib_next = {1'b0, row_in_block_ff} + 4'd1;
   assign closes_brow = in_block_rows &&
                        ((rib_next >= h_eff) || (row_next == {1'b0, block_rows_ff}));

   // counters seen through the fixed 24-bit result fields
   assign bt32 = 32'(block_total_ff);
   assign rt32 = 32'(rem_total_ff);

   // slot table entry fields
   assign rd_valid = rd_ff[ENTRY_W-1];
   assign rd_tag   = rd_ff[COUNT_BITS +: scbs_pkg::TAG_W];
   assign rd_slot  = rd_ff[COUNT_BITS-1:0];
   assign hit      = rd_valid && (rd_tag == tag_ff);
   assign tgt_over = ({1'b0, quo_ff} >= (Q_W+1)'(TABLE_DEPTH));
   assign slot32   = 32'(rd_slot);
   assign ofs_calc = scbs_pkg::OFS_W'(row_in_block_ff) * scbs_pkg::OFS_W'(w_eff) +
                     scbs_pkg::OFS_W'(rem_ff);

   // divider round: DIV_STEP restoring steps on the narrow remainder
   always_comb begin
      logic [scbs_pkg::DIM_W:0]   t;
      logic [scbs_pkg::DIM_W-1:0] r;
      logic [Q_W-1:0]             d, q;
      r = rem_ff;
      d = dvd_ff;
      q = quo_ff;
      for (int i = 0; i < scbs_pkg::DIV_STEP; i++) begin
         t = {r, d[Q_W-1]};
         d = {d[Q_W-2:0], 1'b0};
         if (t >= {1'b0, w_eff}) begin
            t = t - {1'b0, w_eff};
            q = {q[Q_W-2:0], 1'b1};
         end else begin
            q = {q[Q_W-2:0], 1'b0};
         end
         r = t[scbs_pkg::DIM_W-1:0];
      end
      dvd_in = d;
      quo_in = q;
      rem_in = r;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (clr_cnt_ff == AW'(TABLE_DEPTH - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (accept) state_in = ST_ISSUE;
         ST_ISSUE: begin
            if (blocked) begin
               state_in = ST_DIV;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV:   if (div_cnt_ff == scbs_pkg::DIV_CNT_W'(scbs_pkg::DIV_ROUNDS - 1))
                      state_in = ST_READ;
         ST_READ:  state_in = ST_TAG;
         ST_TAG:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // slot table write port: clearing sweep or allocation
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = clr_cnt_ff;
      mem_wdata = '0;
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_TAG && out_free && !tgt_over && !hit) begin
         mem_we    = 1'b1;
         mem_waddr = quo_ff[AW-1:0];
         mem_wdata = {1'b1, tag_ff, block_total_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) table_mem[mem_waddr] <= mem_wdata;
      if (state_ff == ST_READ) rd_ff <= table_mem[quo_ff[AW-1:0]];
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         block_rows_ff   <= '0;
         block_cols_ff   <= '0;
         block_height_ff <= scbs_pkg::DIM_W'(1);
         block_width_ff  <= scbs_pkg::DIM_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            scbs_pkg::CSR_BLOCK_ROWS:   block_rows_ff   <= csr_wdata;
            scbs_pkg::CSR_BLOCK_COLS:   block_cols_ff   <= csr_wdata[12:0];
            scbs_pkg::CSR_BLOCK_HEIGHT: block_height_ff <= csr_wdata[scbs_pkg::DIM_W-1:0];
            scbs_pkg::CSR_BLOCK_WIDTH:  block_width_ff  <= csr_wdata[scbs_pkg::DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_cnt_ff      <= '0;
         row_count_ff    <= '0;
         row_in_block_ff <= '0;
         tag_ff          <= '0;
         block_total_ff  <= '0;
         rem_total_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         div_cnt_ff      <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_cnt_ff <= clr_cnt_ff + AW'(1);
         if (state_ff == ST_DIV) div_cnt_ff <= div_cnt_ff + scbs_pkg::DIV_CNT_W'(1);
         else div_cnt_ff <= '0;

         if (commit) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;

         // counter updates happen when the result is committed
         if (commit && state_ff == ST_ISSUE) begin
            if (cmd_ff == scbs_pkg::CMD_ROW_END) begin
               if (in_block_rows) begin
                  if (closes_brow) begin
                     row_in_block_ff <= '0;
                     tag_ff          <= tag_ff + scbs_pkg::TAG_W'(1);
                  end else begin
                     row_in_block_ff <= rib_next[2:0];
                  end
               end
               if (row_count_ff != 16'hFFFF) row_count_ff <= row_next[15:0];
            end else if (rem_total_ff != '1) begin
               rem_total_ff <= rem_total_ff + COUNT_BITS'(1);
            end
         end
         if (commit && state_ff == ST_TAG && !tgt_over && !hit && block_total_ff != '1) begin
            block_total_ff <= block_total_ff + COUNT_BITS'(1);
         end
      end
   end

   // request capture and divider datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_tuser[0];
         col_ff <= req_tdata[scbs_pkg::COL_W-1:0];
         val_ff <= req_tdata[scbs_pkg::COL_W +: VALUE_BITS];
      end
      if (state_ff == ST_ISSUE) begin
         dvd_ff <= col_ff;
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (state_ff == ST_DIV) begin
         dvd_ff <= dvd_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   // result fields of the request being committed; unused fields stay zero
   always_comb begin
      kind_in   = scbs_pkg::KIND_REMAINDER;
      bslot_in  = '0;
      bcol_in   = '0;
      ofs_in    = '0;
      newb_in   = 1'b0;
      rpos_in   = '0;
      colout_in = '0;
      valout_in = '0;
      rptr_in   = '0;
      brptr_in  = '0;
      brend_in  = 1'b0;
      ovf_in    = 1'b0;
      if (state_ff == ST_TAG) begin
         // blocked entry
         kind_in   = scbs_pkg::KIND_BLOCKED;
         bcol_in   = quo_ff[scbs_pkg::BCOL_W-1:0];
         ofs_in    = ofs_calc;
         valout_in = val_ff;
         if (tgt_over) begin
            ovf_in = 1'b1;
         end else if (hit) begin
            bslot_in = slot32[scbs_pkg::CNT_W-1:0];
         end else begin
            bslot_in = bt32[scbs_pkg::CNT_W-1:0];
            newb_in  = 1'b1;
            ovf_in   = (block_total_ff == '1);
         end
      end else if (cmd_ff == scbs_pkg::CMD_ROW_END) begin
         // row end report
         kind_in = scbs_pkg::KIND_ROW_END;
         rptr_in = rt32[scbs_pkg::CNT_W-1:0];
         if (closes_brow) begin
            brptr_in = bt32[scbs_pkg::CNT_W-1:0];
            brend_in = 1'b1;
         end
         ovf_in = (row_count_ff == 16'hFFFF);
      end else begin
         // remainder entry
         rpos_in   = rt32[scbs_pkg::CNT_W-1:0];
         colout_in = col_ff;
         valout_in = val_ff;
         ovf_in    = (rem_total_ff == '1);
      end
   end

   // result register load
   always_ff @(posedge clock) begin
      if (commit) begin
         kind_ff   <= kind_in;
         bslot_ff  <= bslot_in;
         bcol_ff   <= bcol_in;
         ofs_ff    <= ofs_in;
         newb_ff   <= newb_in;
         rpos_ff   <= rpos_in;
         colout_ff <= colout_in;
         valout_ff <= valout_in;
         rptr_ff   <= rptr_in;
         brptr_ff  <= brptr_in;
         brend_ff  <= brend_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = brend_ff;
   assign rsp_tdata  = {{scbs_pkg::RSP_PAD_W{1'b0}}, ovf_ff, brptr_ff, rptr_ff,
                        scbs_pkg::VALUE_W'(valout_ff), colout_ff, rpos_ff, newb_ff,
                        ofs_ff, bcol_ff, bslot_ff};

   // a block-row close is only ever reported on a row end
   a_brend_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && brend_ff |-> kind_ff == scbs_pkg::KIND_ROW_END)
      else $error("block-row end on a non row-end result");

   // the slot table is written only by the sweep or by an allocation
   a_mem_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CLEAR || state_ff == ST_TAG))
      else $error("slot table written outside sweep or allocation");

   // the remainder count never moves backward
   a_rem_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> rem_total_ff >= $past(rem_total_ff))
      else $error("remainder count decreased");

   // an allocation bumps the block count unless it is saturated
   a_alloc: assert property (@(posedge clock) disable iff (reset)
      commit && state_ff == ST_TAG && !tgt_over && !hit && block_total_ff != '1
      |=> block_total_ff == $past(block_total_ff) + COUNT_BITS'(1))
      else $error("block count not advanced on allocation");

endmodule

/* dv/sparse_csr_to_mixed_block_split_tb.sv */
// Self-checking testbench for the CSR to blocked/remainder splitter: a directed table
// and randomized matrix rows over many register settings.
// Depends on scbs_pkg and sparse_csr_to_mixed_block_split.
`timescale 1ns / 100ps

module sparse_csr_to_mixed_block_split_tb;

   localparam int SLOT_DEPTH      = 4096;
   localparam int NUM_PHASES      = 9;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DRAIN_CYCLES    = 12;

   // result fields, lowest bit first from the bottom of the list
   typedef struct packed {
      logic [scbs_pkg::RSP_PAD_W-1:0] pad;
      logic                           overflow;
      logic [scbs_pkg::CNT_W-1:0]     block_row_pointer;
      logic [scbs_pkg::CNT_W-1:0]     row_pointer;
      logic [scbs_pkg::VALUE_W-1:0]   value_out;
      logic [scbs_pkg::COL_W-1:0]     col_out;
      logic [scbs_pkg::CNT_W-1:0]     remainder_pos;
      logic                           new_block;
      logic [scbs_pkg::OFS_W-1:0]     offset;
      logic [scbs_pkg::BCOL_W-1:0]    block_column;
      logic [scbs_pkg::CNT_W-1:0]     block_slot;
   } rsp_fields_type;

   typedef struct packed {
      logic [1:0]     kind;
      logic           row_close;
      rsp_fields_type f;
   } split_result_type;

   // one line of the directed table: a register write or a request
   typedef struct packed {
      logic             is_write;
      logic [1:0]       reg_idx;
      logic             cmd;
      logic [15:0]      arg;      // column, or register data
      logic [63:0]      value;
      logic             typed;    // hand-written expectation present
      split_result_type want;
   } stim_row_type;

   logic                            clock;
   logic                            reset      = 1'b1;
   logic                            csr_we     = 1'b0;
   logic [1:0]                      csr_addr   = '0;
   logic [15:0]                     csr_wdata  = '0;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [scbs_pkg::REQ_DATA_W-1:0] req_tdata  = '0;   // col, value
   logic [0:0]                      req_tuser  = '0;   // cmd
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [scbs_pkg::RSP_DATA_W-1:0] rsp_tdata;         // see rsp_fields_type
   logic [1:0]                      rsp_tuser;         // kind
   logic                            rsp_tlast;         // block_row_end

   // predictor state and register copies
   logic                            slot_live [SLOT_DEPTH];
   logic [scbs_pkg::TAG_W-1:0]      slot_tag  [SLOT_DEPTH];
   logic [scbs_pkg::CNT_W-1:0]      slot_num  [SLOT_DEPTH];
   logic [15:0]                     row_count;
   logic [2:0]                      row_in_blk;
   logic [scbs_pkg::TAG_W-1:0]      blk_row_tag;
   logic [scbs_pkg::CNT_W-1:0]      blocks_total;
   logic [scbs_pkg::CNT_W-1:0]      remainder_total;
   logic [15:0]                     cfg_rows;
   logic [12:0]                     cfg_cols;
   logic [3:0]                      cfg_height;
   logic [3:0]                      cfg_width;

   split_result_type      split_expected [$];
   bit                    idle_on;
   int                    errors;
   int                    n_blocked, n_remainder, n_row_ends, n_settings;

   stim_row_type dir_tab [32] = '{
      // after reset nothing is blocked: field extremes go to the remainder
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'h0000, value: 64'd0, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_REMAINDER, row_close: 1'b0, f: '0}, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'hFFFF, value: {64{1'b1}}, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_REMAINDER, row_close: 1'b0,
                f: '{remainder_pos: 24'd1, col_out: 16'hFFFF, value_out: {64{1'b1}},
                     default: '0}}, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_ROW_END, row_close: 1'b0,
                f: '{row_pointer: 24'd2, default: '0}}, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_ROWS, arg: 16'd6, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_COLS, arg: 16'h1FFF, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_HEIGHT, arg: 16'd2, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_WIDTH, arg: 16'd0, default: '0},
      // block column past the slot table
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd5000, value: 64'h0123_4567_89AB_CDEF,
        typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_BLOCKED, row_close: 1'b0,
                f: '{block_column: 12'd904, value_out: 64'h0123_4567_89AB_CDEF,
                     overflow: 1'b1, default: '0}}, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd3, value: 64'hA5A5_A5A5_A5A5_A5A5, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_BLOCKED, row_close: 1'b0,
                f: '{block_column: 12'd3, new_block: 1'b1,
                     value_out: 64'hA5A5_A5A5_A5A5_A5A5, default: '0}}, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd3, value: 64'h5A5A_5A5A_5A5A_5A5A, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_BLOCKED, row_close: 1'b0,
                f: '{block_column: 12'd3, value_out: 64'h5A5A_5A5A_5A5A_5A5A,
                     default: '0}}, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_ROW_END, row_close: 1'b0,
                f: '{row_pointer: 24'd2, default: '0}}, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd3, value: 64'd1, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_BLOCKED, row_close: 1'b0,
                f: '{block_column: 12'd3, offset: 6'd1, value_out: 64'd1,
                     default: '0}}, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd4095, value: 64'd2, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_BLOCKED, row_close: 1'b0,
                f: '{block_slot: 24'd1, block_column: 12'd4095, offset: 6'd1,
                     new_block: 1'b1, value_out: 64'd2, default: '0}}, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, typed: 1'b1,
        want: '{kind: scbs_pkg::KIND_ROW_END, row_close: 1'b1,
                f: '{row_pointer: 24'd2, block_row_pointer: 24'd2, default: '0}},
        default: '0},
      // height raised at the start of a block-row, then lowered in the middle of it
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_HEIGHT, arg: 16'd8, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd8, value: 64'hDEAD_BEEF_0000_0001, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_HEIGHT, arg: 16'd1, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd9, value: 64'h8000_0000_0000_0000, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, default: '0},
      // widest blocks, height above range, short last block-row
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_WIDTH, arg: 16'd8, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_HEIGHT, arg: 16'd15, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd8190, value: 64'h0000_0000_FFFF_FFFF,
        default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd7, value: 64'hFFFF_FFFF_0000_0000, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd0, value: 64'h1234, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, default: '0},
      // width above range, empty column region
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_WIDTH, arg: 16'd15, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_COLS, arg: 16'd0, default: '0},
      '{is_write: 1'b1, reg_idx: scbs_pkg::CSR_BLOCK_ROWS, arg: 16'hFFFF, default: '0},
      '{cmd: scbs_pkg::CMD_ENTRY, arg: 16'd0, value: 64'h5555, default: '0},
      '{cmd: scbs_pkg::CMD_ROW_END, default: '0}
   };

   sparse_csr_to_mixed_block_split #(
      .TABLE_DEPTH (SLOT_DEPTH),
      .COUNT_BITS  (scbs_pkg::CNT_W),
      .VALUE_BITS  (scbs_pkg::VALUE_W)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // splits one request the way the block should, updating the predictor state
   function automatic split_result_type predict_split(logic cmd, logic [15:0] col,
                                                      logic [63:0] value);
      split_result_type r;
      int unsigned      h, w, target, next;
      r = '0;
      h = (cfg_height == 0) ? 1 : (cfg_height > 8) ? 8 : cfg_height;
      w = (cfg_width == 0) ? 1 : (cfg_width > 8) ? 8 : cfg_width;
      if (cmd == scbs_pkg::CMD_ENTRY) begin
         r.f.value_out = value;
         if (row_count < cfg_rows && col < cfg_cols) begin
            target = col / w;
            r.kind = scbs_pkg::KIND_BLOCKED;
            r.f.block_column = target[scbs_pkg::BCOL_W-1:0];
            r.f.offset = scbs_pkg::OFS_W'(row_in_blk * w + col % w);
            if (target >= SLOT_DEPTH) begin
               r.f.overflow = 1'b1;
            end else if (slot_live[target] && slot_tag[target] == blk_row_tag) begin
               r.f.block_slot = slot_num[target];
            end else begin
               // first entry of this block column in the block-row
               slot_live[target] = 1'b1;
               slot_tag[target] = blk_row_tag;
               slot_num[target] = blocks_total;
               r.f.block_slot = blocks_total;
               r.f.new_block = 1'b1;
               if (blocks_total != '1) blocks_total++;
               else r.f.overflow = 1'b1;
            end
         end else begin
            r.kind = scbs_pkg::KIND_REMAINDER;
            r.f.remainder_pos = remainder_total;
            r.f.col_out = col;
            if (remainder_total != '1) remainder_total++;
            else r.f.overflow = 1'b1;
         end
      end else begin
         r.kind = scbs_pkg::KIND_ROW_END;
         r.f.row_pointer = remainder_total;
         if (row_count < cfg_rows) begin
            next = row_in_blk + 1;
            if (next >= h || int'(row_count) + 1 == int'(cfg_rows)) begin
               r.f.block_row_pointer = blocks_total;
               r.row_close = 1'b1;
               row_in_blk = '0;
               blk_row_tag++;
            end else begin
               row_in_blk = next[2:0];
            end
         end
         if (row_count != 16'hFFFF) row_count++;
         else r.f.overflow = 1'b1;
      end
      return r;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         scbs_pkg::CSR_BLOCK_ROWS:   cfg_rows = data;
         scbs_pkg::CSR_BLOCK_COLS:   cfg_cols = data[12:0];
         scbs_pkg::CSR_BLOCK_HEIGHT: cfg_height = data[3:0];
         default:                    cfg_width = data[3:0];
      endcase
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // hold the request side idle until every expected result is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (split_expected.size() != 0) @(posedge clock);
   endtask

   // one request; the expectation is the typed one if given, else the predicted one
   task automatic send_req(logic cmd, logic [15:0] col, logic [63:0] value,
                           logic typed, split_result_type want);
      int               gap;
      split_result_type r;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {value, col};
      do @(posedge clock); while (!req_tready);
      r = predict_split(cmd, col, value);
      split_expected.push_back(typed ? want : r);
   endtask

   // result-side stalls in random bursts
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 6);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      split_result_type exp_r;
      rsp_fields_type   got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (split_expected.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, actual kind %0d",
                     $time, rsp_tuser);
         end else begin
            exp_r = split_expected.pop_front();
            check_field("kind", exp_r.kind, rsp_tuser);
            check_field("block_row_end", exp_r.row_close, rsp_tlast);
            check_field("block_slot", exp_r.f.block_slot, got.block_slot);
            check_field("block_column", exp_r.f.block_column, got.block_column);
            check_field("offset", exp_r.f.offset, got.offset);
            check_field("new_block", exp_r.f.new_block, got.new_block);
            check_field("remainder_pos", exp_r.f.remainder_pos, got.remainder_pos);
            check_field("col_out", exp_r.f.col_out, got.col_out);
            check_field("value_out", exp_r.f.value_out, got.value_out);
            check_field("row_pointer", exp_r.f.row_pointer, got.row_pointer);
            check_field("block_row_pointer", exp_r.f.block_row_pointer,
                        got.block_row_pointer);
            check_field("overflow", exp_r.f.overflow, got.overflow);
            case (exp_r.kind)
               scbs_pkg::KIND_BLOCKED:   n_blocked++;
               scbs_pkg::KIND_REMAINDER: n_remainder++;
               default:                  n_row_ends++;
            endcase
         end
      end
   end

   // main sequence
   initial begin
      int          n_sent, n_ent, sel, lim;
      logic [15:0] col, data;
      logic [63:0] value;

      foreach (slot_live[i]) slot_live[i] = 1'b0;
      row_count       = '0;
      row_in_blk      = '0;
      blk_row_tag     = '0;
      blocks_total    = '0;
      remainder_total = '0;
      cfg_rows        = '0;
      cfg_cols        = '0;
      cfg_height      = 4'd1;
      cfg_width       = 4'd1;
      errors          = 0;
      idle_on         = 1'b1;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (dir_tab[i]) begin
         if (dir_tab[i].is_write) begin
            wait_for_results();
            write_reg(dir_tab[i].reg_idx, dir_tab[i].arg);
            n_settings++;
         end else begin
            send_req(dir_tab[i].cmd, dir_tab[i].arg, dir_tab[i].value,
                     dir_tab[i].typed, dir_tab[i].want);
         end
      end

      // random matrices, one register setting per phase
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_for_results();
         idle_on = (ph != 3) && (ph != NUM_PHASES - 1);
         case ($urandom_range(0, 5))
            0:       data = 16'h0000;
            1:       data = 16'hFFFF;
            default: data = 16'(row_count + $urandom_range(1, 60));
         endcase
         write_reg(scbs_pkg::CSR_BLOCK_ROWS, data);
         case ($urandom_range(0, 5))
            0:       data = 16'd0;
            1:       data = 16'h1FFF;
            2:       data = 16'd4096;
            3:       data = 16'($urandom_range(0, 8191));
            default: data = 16'($urandom_range(1, 64));
         endcase
         write_reg(scbs_pkg::CSR_BLOCK_COLS, data);
         for (int d = 0; d < 2; d++) begin
            case ($urandom_range(0, 5))
               0:       data = 16'd0;
               1:       data = 16'd15;
               2:       data = 16'd8;
               default: data = 16'($urandom_range(1, 8));
            endcase
            write_reg(d == 0 ? scbs_pkg::CSR_BLOCK_HEIGHT : scbs_pkg::CSR_BLOCK_WIDTH, data);
         end
         n_settings++;

         n_sent = 0;
         while (n_sent < ITEMS_PER_PHASE) begin
            n_ent = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
            repeat (n_ent) begin
               // mostly narrow columns inside the blocked region so block columns repeat
               sel = $urandom_range(0, 3);
               lim = (cfg_cols > 64) ? 64 : cfg_cols;
               if (cfg_cols != 0 && sel < 2) col = 16'($urandom_range(0, lim - 1));
               else if (cfg_cols != 0 && sel == 2) col = 16'($urandom_range(0, cfg_cols - 1));
               else col = 16'($urandom_range(0, 16'hFFFF));
               value = {$urandom, $urandom};
               send_req(scbs_pkg::CMD_ENTRY, col, value, 1'b0, '0);
               n_sent++;
            end
            send_req(scbs_pkg::CMD_ROW_END, '0, '0, 1'b0, '0);
            n_sent++;
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d blocked entries, %0d remainder entries and %0d row ends",
               n_blocked, n_remainder, n_row_ends);
      $display("over %0d register settings, with and without stalls on both sides",
               n_settings);
      if (errors == 0 && split_expected.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
